FILE: rtl/ptd_pkg.sv
// Package for the periodic task dispatcher.
// Word kind codes, field widths and the memory control struct; no dependencies.
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int KIND_W = 2;
  localparam int TICK_W = 32;
  localparam int IDX_OUT_W = 3;

  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic per_we;
    logic run_we;
  } mem_ctl_t;

endpackage

FILE: rtl/periodic_task_dispatcher.sv
// Periodic task dispatcher top level: control sequencer, tick counter, output register.
// Instantiates ptd_task_mem; uses ptd_pkg.
//
//   channel | direction | handshake                  | fields
//   in      | input     | in_valid_i / in_stall_o    | kind_i, period_i
//   out     | output    | out_valid_o / out_stall_i  | status_o, fired_o, task_index_o, last_o
//
// A dispatch reads one table entry per cycle through the single memory read port,
// except while a due word or the closing word waits on a stalled output register.
// Reset clears last-run valid bits at once; no clearing pass. Input is stalled during
// a dispatch scan and whenever the output register is full and stalled.
`timescale 1ns / 1ps

module periodic_task_dispatcher #(
  parameter int MAX_TASKS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ptd_pkg::KIND_W-1:0]    kind_i,
  input  logic [ptd_pkg::TICK_W-1:0]    period_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          status_o,
  output logic                          fired_o,
  output logic [ptd_pkg::IDX_OUT_W-1:0] task_index_o,
  output logic                          last_o
);
  import ptd_pkg::*;

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);

  state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              ev_vld_q, ev_vld_d;
  logic [AW-1:0]     ev_idx_q, ev_idx_d;
  logic              pend_vld_q, pend_vld_d;
  logic [AW-1:0]     pend_idx_q, pend_idx_d;

  logic              out_vld_q, out_vld_d;
  logic              out_status_q, out_status_d;
  logic              out_fired_q, out_fired_d;
  logic [AW-1:0]     out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;
  logic              out_ld;

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     wr_addr;
  logic [TICK_W-1:0] wr_data;
  logic [TICK_W-1:0] per_rd;
  logic [TICK_W-1:0] run_rd;

  logic              out_free;
  logic              acc;
  logic [TICK_W-1:0] elapsed;
  logic              ev_fire;
  logic              blocked;
  logic              issue;
  logic              finish;
  logic [AW+2:0]     idx_ext;

  ptd_task_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_idx_q[AW-1:0]),
    .per_o     (per_rd),
    .run_o     (run_rd)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign acc        = in_valid_i && !in_stall_o;

  assign elapsed = tick_q - run_rd;
  assign ev_fire = ev_vld_q && (elapsed > per_rd);
  assign blocked = ev_fire && pend_vld_q && !out_free;
  assign issue   = (state_q == ST_SCAN) && !blocked && (rd_idx_q < cnt_q);
  assign finish  = (state_q == ST_SCAN) && !ev_vld_q && (rd_idx_q >= cnt_q) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && kind_i == KIND_DISPATCH && cnt_q != '0) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d        = cnt_q;
    tick_d       = tick_q;
    rd_idx_d     = rd_idx_q;
    ev_vld_d     = ev_vld_q;
    ev_idx_d     = ev_idx_q;
    pend_vld_d   = pend_vld_q;
    pend_idx_d   = pend_idx_q;
    out_ld       = 1'b0;
    out_status_d = STATUS_OK;
    out_fired_d  = 1'b0;
    out_idx_d    = '0;
    out_last_d   = 1'b1;
    mem_ctl      = '0;
    wr_addr      = ev_idx_q;
    wr_data      = tick_q;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (kind_i)
            KIND_ADD: begin
              out_ld = 1'b1;
              if (cnt_q < CNT_MAX) begin
                mem_ctl.per_we = 1'b1;
                wr_addr        = cnt_q[AW-1:0];
                wr_data        = period_i;
                out_idx_d      = cnt_q[AW-1:0];
                cnt_d          = cnt_q + 1'b1;
              end else begin
                out_status_d = STATUS_FAIL;
              end
            end
            KIND_TICK: begin
              tick_d = tick_q + 1'b1;
            end
            KIND_DISPATCH: begin
              if (cnt_q == '0) begin
                out_ld       = 1'b1;
                out_status_d = STATUS_FAIL;
              end else begin
                rd_idx_d   = '0;
                ev_vld_d   = 1'b0;
                pend_vld_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!blocked) begin
          if (ev_fire) begin
            mem_ctl.run_we = 1'b1;
            pend_vld_d     = 1'b1;
            pend_idx_d     = ev_idx_q;
            if (pend_vld_q) begin
              out_ld      = 1'b1;
              out_fired_d = 1'b1;
              out_idx_d   = pend_idx_q;
              out_last_d  = 1'b0;
            end
          end
          mem_ctl.rd_en = issue;
          ev_vld_d      = issue;
          if (issue) begin
            ev_idx_d = rd_idx_q[AW-1:0];
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (finish) begin
          out_ld      = 1'b1;
          out_fired_d = pend_vld_q;
          out_idx_d   = pend_vld_q ? pend_idx_q : '0;
          pend_vld_d  = 1'b0;
        end
      end
      default: ;
    endcase

    if (out_ld) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      tick_q     <= '0;
      rd_idx_q   <= '0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      tick_q     <= tick_d;
      rd_idx_q   <= rd_idx_d;
      ev_vld_q   <= ev_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q   <= ev_idx_d;
    pend_idx_q <= pend_idx_d;
    if (out_ld) begin
      out_status_q <= out_status_d;
      out_fired_q  <= out_fired_d;
      out_idx_q    <= out_idx_d;
      out_last_q   <= out_last_d;
    end
  end

  assign idx_ext = {3'b000, out_idx_q};

  assign out_valid_o  = out_vld_q;
  assign status_o     = out_status_q;
  assign fired_o      = out_fired_q;
  assign task_index_o = idx_ext[IDX_OUT_W-1:0];
  assign last_o       = out_last_q;

endmodule

FILE: rtl/ptd_task_mem.sv
// Task table memory: period and last-run arrays, one write and one read port.
// Last-run entries carry valid bits so reset reads as zero. Uses ptd_pkg.
`timescale 1ns / 1ps

module ptd_task_mem #(
  parameter int DEPTH = 8,
  parameter int AW = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptd_pkg::mem_ctl_t          ctl_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [ptd_pkg::TICK_W-1:0] wr_data_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [ptd_pkg::TICK_W-1:0] per_o,
  output logic [ptd_pkg::TICK_W-1:0] run_o
);
  import ptd_pkg::*;

  logic [TICK_W-1:0] per_mem [DEPTH];
  logic [TICK_W-1:0] run_mem [DEPTH];
  logic [DEPTH-1:0]  run_vld_q;

  logic [TICK_W-1:0] per_rd_q;
  logic [TICK_W-1:0] run_rd_q;
  logic              run_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.per_we) begin
      per_mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.run_we) begin
      run_mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      per_rd_q     <= per_mem[rd_addr_i];
      run_rd_q     <= run_mem[rd_addr_i];
      run_rd_vld_q <= run_vld_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_vld_q <= '0;
    end else if (ctl_i.run_we) begin
      run_vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign per_o = per_rd_q;
  assign run_o = run_rd_vld_q ? run_rd_q : '0;

endmodule
